### src/rtru_pkg.sv
// Shared types and constants for the region table range unmap unit.
// No dependencies; used by every module under src but rtru_ram.
package rtru_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 64;
   localparam int ADDR_BITS_DEFAULT   = 48;
   localparam int PROT_W              = 3;

   // request codes; code 3 is unused and only answers the count
   typedef enum logic [1:0] {
      REQ_TRACK = 2'd0,
      REQ_UNMAP = 2'd1,
      REQ_READ  = 2'd2
   } req_code_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_APPEND,
      ST_READ
   } state_type;

   // how one stored region relates to the range being removed
   typedef struct packed {
      logic hit;   // region and range overlap
      logic head;  // part of the region lies below the range
      logic tail;  // part of the region lies above the range
   } region_class_type;

endpackage

### src/rtru_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rtru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/rtru_region_eval.sv
// Classifies one stored region [base, lim) against the unmap range [lo, hi).
// Depends on rtru_pkg.
module rtru_region_eval #(
   parameter int ADDR_BITS = rtru_pkg::ADDR_BITS_DEFAULT
) (
   input  logic [ADDR_BITS-1:0]       range_lo,
   input  logic [ADDR_BITS:0]         range_hi,
   input  logic [ADDR_BITS-1:0]       region_base,
   input  logic [ADDR_BITS:0]         region_lim,
   output rtru_pkg::region_class_type cls
);

   logic [ADDR_BITS:0] lo_ext;
   logic [ADDR_BITS:0] base_ext;

   assign lo_ext   = {1'b0, range_lo};
   assign base_ext = {1'b0, region_base};

   always_comb begin
      cls.hit  = !((lo_ext >= region_lim) || (range_hi <= base_ext));
      cls.head = region_base < range_lo;
      cls.tail = range_hi < region_lim;
   end

endmodule

### src/region_table_range_unmap_unit.sv
// Region table range unmap unit: top level. Keeps an unordered table of address
// regions in one RAM and serves track, unmap and read requests.
// Depends on rtru_pkg, rtru_ram and rtru_region_eval.
//
// A request word is taken when start is high and busy is low; exactly one
// response word follows, shown on the rsp_ ports for one cycle with rsp_valid
// high. The receiver cannot stall, so it must take every word as it comes.
// Timing: track, an unknown code, an empty unmap, an unmap of an empty table
// and a read past the count answer on the cycle after the request and busy
// stays low throughout. A read that hits passes through ST_READ and then the
// response register. An unmap walks the table through the single read port
// of the region RAM, one entry at a time (an entry pulled in from the end to
// fill a removed slot is examined in that slot and not again at the end);
// each straddled entry adds an ST_APPEND step for the tail append, and the
// response is registered after the walk ends. Region memory is not cleared
// at reset; only entries below the count are ever used.
module region_table_range_unmap_unit #(
   parameter int TABLE_DEPTH = rtru_pkg::TABLE_DEPTH_DEFAULT,
   parameter int ADDR_BITS   = rtru_pkg::ADDR_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  start,
   output logic                                  busy,
   input  logic [1:0]                            req_type,
   input  logic [ADDR_BITS-1:0]                  req_range_start,
   input  logic [ADDR_BITS:0]                    req_range_end,
   input  logic [rtru_pkg::PROT_W-1:0]           req_prot_bits,
   input  logic [$clog2(TABLE_DEPTH)-1:0]        req_entry_index,
   // response channel
   output logic                                  rsp_valid,
   output logic [ADDR_BITS-1:0]                  rsp_entry_base,
   output logic [ADDR_BITS:0]                    rsp_entry_length,
   output logic [rtru_pkg::PROT_W-1:0]           rsp_entry_prot,
   output logic                                  rsp_entry_present,
   output logic [$clog2(TABLE_DEPTH+1)-1:0]      rsp_region_count,
   output logic                                  rsp_overflow
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int PW    = rtru_pkg::PROT_W;
   // RAM word: {base, exclusive end, prot}
   localparam int MEM_W = ADDR_BITS + (ADDR_BITS + 1) + PW;

   // ---------------------------------------------------------------- state
   rtru_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;       // walk pointer
   logic                   moved_ff, moved_in;   // slot holds the entry moved from the end
   logic                   ovf_ff, ovf_in;
   logic [ADDR_BITS-1:0]   lo_ff, lo_in;
   logic [ADDR_BITS:0]     hi_ff, hi_in;
   logic [ADDR_BITS:0]     tail_lim_ff, tail_lim_in;
   logic [PW-1:0]          tail_prot_ff, tail_prot_in;
   logic                   fwd_hit_ff, fwd_hit_in;
   logic [MEM_W-1:0]       fwd_data_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ADDR_BITS-1:0]   rsp_base_ff, rsp_base_in;
   logic [ADDR_BITS:0]     rsp_len_ff, rsp_len_in;
   logic [PW-1:0]          rsp_prot_ff, rsp_prot_in;
   logic                   rsp_present_ff, rsp_present_in;
   logic [CNT_W-1:0]       rsp_count_ff, rsp_count_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;

   // ---------------------------------------------------------------- RAM
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [MEM_W-1:0]       wr_data;
   logic [IDX_W-1:0]       rd_addr;
   logic [MEM_W-1:0]       ram_q;

   rtru_ram #(
      .WIDTH (MEM_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // Same-cycle write and read of one slot: take the written word instead.
   logic [MEM_W-1:0]       cur_word;
   logic [ADDR_BITS-1:0]   cur_base;
   logic [ADDR_BITS:0]     cur_lim;
   logic [PW-1:0]          cur_prot;

   assign cur_word = fwd_hit_ff ? fwd_data_ff : ram_q;
   assign {cur_base, cur_lim, cur_prot} = cur_word;

   rtru_pkg::region_class_type cls;

   rtru_region_eval #(
      .ADDR_BITS (ADDR_BITS)
   ) u_eval (
      .range_lo    (lo_ff),
      .range_hi    (hi_ff),
      .region_base (cur_base),
      .region_lim  (cur_lim),
      .cls         (cls)
   );

   // ---------------------------------------------------------------- decode
   logic                   accept;
   logic [ADDR_BITS:0]     hi_sat;      // end clipped to the address space
   logic                   nonempty;
   logic                   room;        // table has a free slot
   logic                   read_hit;
   logic [CNT_W-1:0]       idx_ext;
   logic                   next_ok;     // pointer + 1 still below the count
   logic                   next_ok_app; // same, after an append
   logic                   move_ok;     // a later entry exists to move down
   logic                   covered;
   logic                   straddle;
   logic                   finish;

   assign accept   = start && !busy;
   assign hi_sat   = (req_range_end[ADDR_BITS] && (|req_range_end[ADDR_BITS-1:0])) ?
                     {1'b1, {ADDR_BITS{1'b0}}} : req_range_end;
   assign nonempty = hi_sat > {1'b0, req_range_start};
   assign room     = count_ff < CNT_W'(TABLE_DEPTH);
   assign read_hit = CNT_W'(req_entry_index) < count_ff;
   assign idx_ext  = CNT_W'(idx_ff);
   assign next_ok  = (idx_ext + CNT_W'(1)) < count_ff;
   assign next_ok_app = (idx_ext + CNT_W'(1)) < (count_ff + CNT_W'(room));
   assign move_ok  = idx_ext < (count_ff - CNT_W'(1));
   assign covered  = cls.hit && !cls.head && !cls.tail;
   assign straddle = cls.hit && cls.head && cls.tail;

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rtru_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_type == rtru_pkg::REQ_UNMAP && nonempty && count_ff != '0) begin
                  state_in = rtru_pkg::ST_WALK;
               end else if (req_type == rtru_pkg::REQ_READ && read_hit) begin
                  state_in = rtru_pkg::ST_READ;
               end
            end
         end
         rtru_pkg::ST_WALK: begin
            if (straddle) begin
               state_in = rtru_pkg::ST_APPEND;
            end else if (covered) begin
               state_in = move_ok ? rtru_pkg::ST_WALK : rtru_pkg::ST_IDLE;
            end else begin
               state_in = next_ok ? rtru_pkg::ST_WALK : rtru_pkg::ST_IDLE;
            end
         end
         rtru_pkg::ST_APPEND: begin
            state_in = next_ok_app ? rtru_pkg::ST_WALK : rtru_pkg::ST_IDLE;
         end
         rtru_pkg::ST_READ: begin
            state_in = rtru_pkg::ST_IDLE;
         end
         default: begin
            state_in = rtru_pkg::ST_IDLE;
         end
      endcase
   end

   // a response goes out whenever a request ends this cycle
   assign finish = (state_in == rtru_pkg::ST_IDLE) &&
                   (accept || state_ff != rtru_pkg::ST_IDLE);

   // ---------------------------------------------------------------- datapath
   always_comb begin
      count_in     = count_ff;
      idx_in       = idx_ff;
      moved_in     = moved_ff;
      ovf_in       = ovf_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      tail_lim_in  = tail_lim_ff;
      tail_prot_in = tail_prot_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = cur_word;
      rd_addr      = idx_ff;

      case (state_ff)
         rtru_pkg::ST_IDLE: begin
            if (accept) begin
               lo_in    = req_range_start;
               hi_in    = hi_sat;
               idx_in   = '0;
               moved_in = 1'b0;
               ovf_in   = 1'b0;
               rd_addr  = (req_type == rtru_pkg::REQ_READ) ? req_entry_index : '0;
               if (req_type == rtru_pkg::REQ_TRACK && nonempty) begin
                  if (room) begin
                     wr_en    = 1'b1;
                     wr_addr  = count_ff[IDX_W-1:0];
                     wr_data  = {req_range_start, hi_sat, req_prot_bits};
                     count_in = count_ff + CNT_W'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
            end
         end
         rtru_pkg::ST_WALK: begin
            if (covered) begin
               // drop this slot: pull the last entry in and look at it again
               count_in = count_ff - CNT_W'(1);
               if (move_ok) begin
                  rd_addr  = count_in[IDX_W-1:0];
                  moved_in = 1'b1;
               end
            end else begin
               if (!cls.hit) begin
                  wr_en = moved_ff;
               end else if (cls.head) begin
                  wr_en   = 1'b1;
                  wr_data = {cur_base, {1'b0, lo_ff}, cur_prot};
               end else begin
                  wr_en   = 1'b1;
                  wr_data = {hi_ff[ADDR_BITS-1:0], cur_lim, cur_prot};
               end
               if (straddle) begin
                  tail_lim_in  = cur_lim;
                  tail_prot_in = cur_prot;
                  moved_in     = 1'b0;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  rd_addr  = idx_ff + IDX_W'(1);
                  moved_in = 1'b0;
               end
            end
         end
         rtru_pkg::ST_APPEND: begin
            if (room) begin
               wr_en    = 1'b1;
               wr_addr  = count_ff[IDX_W-1:0];
               wr_data  = {hi_ff[ADDR_BITS-1:0], tail_lim_ff, tail_prot_ff};
               count_in = count_ff + CNT_W'(1);
            end else begin
               ovf_in = 1'b1;
            end
            idx_in  = idx_ff + IDX_W'(1);
            rd_addr = idx_ff + IDX_W'(1);
         end
         rtru_pkg::ST_READ: begin
         end
         default: begin
         end
      endcase

      fwd_hit_in = wr_en && (wr_addr == rd_addr);

      rsp_valid_in   = finish;
      rsp_base_in    = '0;
      rsp_len_in     = '0;
      rsp_prot_in    = '0;
      rsp_present_in = 1'b0;
      rsp_count_in   = count_in;
      rsp_ovf_in     = ovf_in;
      if (state_ff == rtru_pkg::ST_READ) begin
         rsp_base_in    = cur_base;
         rsp_len_in     = cur_lim - {1'b0, cur_base};
         rsp_prot_in    = cur_prot;
         rsp_present_in = 1'b1;
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rtru_pkg::ST_IDLE;
         count_ff     <= '0;
         moved_ff     <= 1'b0;
         ovf_ff       <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         moved_ff     <= moved_in;
         ovf_ff       <= ovf_in;
         fwd_hit_ff   <= fwd_hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      tail_lim_ff    <= tail_lim_in;
      tail_prot_ff   <= tail_prot_in;
      fwd_data_ff    <= wr_data;
      rsp_base_ff    <= rsp_base_in;
      rsp_len_ff     <= rsp_len_in;
      rsp_prot_ff    <= rsp_prot_in;
      rsp_present_ff <= rsp_present_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_ovf_ff     <= rsp_ovf_in;
   end

   // ---------------------------------------------------------------- ports
   assign busy              = state_ff != rtru_pkg::ST_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_entry_base    = rsp_base_ff;
   assign rsp_entry_length  = rsp_len_ff;
   assign rsp_entry_prot    = rsp_prot_ff;
   assign rsp_entry_present = rsp_present_ff;
   assign rsp_region_count  = rsp_count_ff;
   assign rsp_overflow      = rsp_ovf_ff;

   // ---------------------------------------------------------------- checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_walk_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == rtru_pkg::ST_WALK |-> idx_ext < count_ff)
      else $error("walk pointer past the entry count");

   a_write_addr: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> CNT_W'(wr_addr) <= count_ff)
      else $error("table write beyond the fill point");

   a_read_answer: assert property (@(posedge clock) disable iff (reset)
      state_ff == rtru_pkg::ST_READ |=> rsp_valid && rsp_entry_present)
      else $error("read hit gave no present response");

endmodule

### sim/tb_top.sv
// Self-checking testbench for region_table_range_unmap_unit: track, unmap and read words
// are checked, field by field, against a region table kept inside the bench.
// Depends on rtru_pkg and region_table_range_unmap_unit.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = rtru_pkg::TABLE_DEPTH_DEFAULT;
   localparam int AW = rtru_pkg::ADDR_BITS_DEFAULT;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   // code 3 is not in the package enum; the block only answers the count
   localparam logic [1:0] REQ_NONE = 2'd3;
   // one past the last address; request ends saturate here
   localparam logic [AW:0] ADDR_TOP = {1'b1, {AW{1'b0}}};
   localparam int IDLE_LIMIT = 4000;
   localparam int RANDOM_WORDS = 1150;

   // ---------------------------------------------------------------- DUT
   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic [1:0]                    req_type = '0;
   logic [AW-1:0]                 req_range_start = '0;
   logic [AW:0]                   req_range_end = '0;
   logic [rtru_pkg::PROT_W-1:0]   req_prot_bits = '0;
   logic [IDX_W-1:0]              req_entry_index = '0;
   logic                          rsp_valid;
   logic [AW-1:0]                 rsp_entry_base;
   logic [AW:0]                   rsp_entry_length;
   logic [rtru_pkg::PROT_W-1:0]   rsp_entry_prot;
   logic                          rsp_entry_present;
   logic [CNT_W-1:0]              rsp_region_count;
   logic                          rsp_overflow;

   region_table_range_unmap_unit dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_range_start   (req_range_start),
      .req_range_end     (req_range_end),
      .req_prot_bits     (req_prot_bits),
      .req_entry_index   (req_entry_index),
      .rsp_valid         (rsp_valid),
      .rsp_entry_base    (rsp_entry_base),
      .rsp_entry_length  (rsp_entry_length),
      .rsp_entry_prot    (rsp_entry_prot),
      .rsp_entry_present (rsp_entry_present),
      .rsp_region_count  (rsp_region_count),
      .rsp_overflow      (rsp_overflow)
   );

   // 4 ns period
   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------- region table
   // Bench copy of the table. Entries at or above tbl_count are stale and never read.
   typedef struct packed {
      logic [AW-1:0]               base;
      logic [AW:0]                 length;
      logic [rtru_pkg::PROT_W-1:0] prot;
      logic                        present;
      logic [CNT_W-1:0]            count;
      logic                        ovf;
   } rsp_word_type;

   logic [AW-1:0]               tbl_base [DEPTH];
   logic [AW:0]                 tbl_len  [DEPTH];
   logic [rtru_pkg::PROT_W-1:0] tbl_prot [DEPTH];
   int                          tbl_count = 0;

   rsp_word_type due_rsp_q [$];   // responses owed by the block, oldest first
   int           errors = 0;
   int           burst_left = 1;
   int           idle_cycles = 0;

   // false when the table is already full (append dropped)
   function automatic bit tbl_append(logic [AW-1:0] b, logic [AW:0] len,
                                     logic [rtru_pkg::PROT_W-1:0] p);
      if (tbl_count >= DEPTH) return 1'b0;
      tbl_base[tbl_count] = b;
      tbl_len[tbl_count]  = len;
      tbl_prot[tbl_count] = p;
      tbl_count++;
      return 1'b1;
   endfunction

   // Cut [lo, hi) out of every region; true if a straddle tail was dropped.
   // 50-bit math so base + length never wraps.
   function automatic bit tbl_unmap(logic [AW+1:0] lo, logic [AW+1:0] hi);
      logic [AW+1:0] b, e, diff;
      bit            head, tail, dropped;
      int            i;
      dropped = 1'b0;
      i = 0;
      while (i < tbl_count) begin
         b = {2'b00, tbl_base[i]};
         e = b + {1'b0, tbl_len[i]};
         if (lo >= e || hi <= b) begin
            i++;
            continue;
         end
         head = b < lo;
         tail = hi < e;
         if (!head && !tail) begin
            // fully covered: last entry fills the hole, slot is looked at again
            tbl_count--;
            tbl_base[i] = tbl_base[tbl_count];
            tbl_len[i]  = tbl_len[tbl_count];
            tbl_prot[i] = tbl_prot[tbl_count];
            continue;
         end
         if (head) begin
            diff = lo - b;
            tbl_len[i] = diff[AW:0];
         end else begin
            diff = e - hi;
            tbl_base[i] = hi[AW-1:0];
            tbl_len[i]  = diff[AW:0];
         end
         if (head && tail) begin
            // straddle: head stays in place, tail goes to the end of the table
            diff = e - hi;
            if (!tbl_append(hi[AW-1:0], diff[AW:0], tbl_prot[i])) dropped = 1'b1;
         end
         i++;
      end
      return dropped;
   endfunction

   // Applies one accepted request to the bench table and returns the response it owes.
   function automatic rsp_word_type apply_request(logic [1:0] code, logic [AW-1:0] s,
                                                  logic [AW:0] e,
                                                  logic [rtru_pkg::PROT_W-1:0] p,
                                                  logic [IDX_W-1:0] idx);
      rsp_word_type  r;
      logic [AW+1:0] lo, hi, span;
      r  = '0;
      lo = {2'b00, s};
      hi = {1'b0, e};
      if (hi > {1'b0, ADDR_TOP}) hi = {1'b0, ADDR_TOP};
      span = hi - lo;
      case (code)
         rtru_pkg::REQ_TRACK: begin
            if (hi > lo && !tbl_append(s, span[AW:0], p)) r.ovf = 1'b1;
         end
         rtru_pkg::REQ_UNMAP: begin
            if (hi > lo && tbl_unmap(lo, hi)) r.ovf = 1'b1;
         end
         rtru_pkg::REQ_READ: begin
            if (int'(idx) < tbl_count) begin
               r.base    = tbl_base[idx];
               r.length  = tbl_len[idx];
               r.prot    = tbl_prot[idx];
               r.present = 1'b1;
            end
         end
         default: ;
      endcase
      r.count = tbl_count[CNT_W-1:0];
      return r;
   endfunction

   // ---------------------------------------------------------------- sender
   // Sender runs in bursts; start stays high across back-to-back words and only
   // drops when a gap is taken, so it is never lowered and raised in one step.
   task automatic pace_sender();
      int gap;
      burst_left--;
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         // now and then a long stretch with no gaps at all
         burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
      end
   endtask

   // Drives one request word at the current edge, waits for the edge that
   // takes it, then books the expected response.
   task automatic send_word(input logic [1:0] code, input logic [AW-1:0] lo,
                            input logic [AW:0] hi,
                            input logic [rtru_pkg::PROT_W-1:0] p,
                            input logic [IDX_W-1:0] idx);
      req_type        <= code;
      req_range_start <= lo;
      req_range_end   <= hi;
      req_prot_bits   <= p;
      req_entry_index <= idx;
      start           <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      due_rsp_q.push_back(apply_request(code, lo, hi, p, idx));
      pace_sender();
   endtask

   function automatic logic [AW-1:0] rand_addr();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      return r[AW-1:0];
   endfunction

   function automatic logic [AW:0] rand_end();
      return {1'($urandom_range(0, 1)), rand_addr()};
   endfunction

   function automatic logic [rtru_pkg::PROT_W-1:0] rand_prot();
      return rtru_pkg::PROT_W'($urandom_range(0, 7));
   endfunction

   function automatic logic [IDX_W-1:0] rand_idx();
      return IDX_W'($urandom_range(0, DEPTH - 1));
   endfunction

   // ---------------------------------------------------------------- tests
   // Extremes of every field, each request code and the edge cases by hand.
   task automatic test_directed();
      send_word(rtru_pkg::REQ_READ, '0, '0, '0, '0);                 // read on empty table
      send_word(rtru_pkg::REQ_READ, '1, '1, '1, IDX_W'(DEPTH - 1));
      // end saturates at the top
      send_word(rtru_pkg::REQ_TRACK, '0, {(AW + 1){1'b1}}, 3'd7, '0);
      send_word(rtru_pkg::REQ_READ, '0, '0, '0, '0);
      send_word(rtru_pkg::REQ_UNMAP, '0, ADDR_TOP, '0, '0);          // whole space
      // last byte of the space
      send_word(rtru_pkg::REQ_TRACK, {AW{1'b1}}, ADDR_TOP, 3'd0, '0);
      send_word(rtru_pkg::REQ_TRACK, 48'h100, 49'h100, 3'd1, '0);    // empty track
      send_word(rtru_pkg::REQ_TRACK, 48'h200, 49'h100, 3'd1, '0);    // inverted track
      send_word(rtru_pkg::REQ_TRACK, 48'h1000, 49'h2000, 3'd5, '0);
      send_word(rtru_pkg::REQ_TRACK, 48'h3000, 49'h4000, 3'd2, '0);
      send_word(rtru_pkg::REQ_TRACK, 48'h5000, 49'h6000, 3'd3, '0);
      send_word(rtru_pkg::REQ_UNMAP, 48'h6000, 49'h1000, '0, '0);    // inverted unmap
      send_word(rtru_pkg::REQ_UNMAP, 48'h1800, 49'h1800, '0, '0);    // empty unmap
      send_word(rtru_pkg::REQ_UNMAP, 48'h1800, 49'h3400, '0, '0);    // head trim + tail trim
      send_word(rtru_pkg::REQ_UNMAP, 48'h5400, 49'h5800, '0, '0);    // straddle, tail appended
      send_word(rtru_pkg::REQ_UNMAP, 48'h5000, 49'h5400, '0, '0);    // full cover, last moves in
      for (int k = 0; k < 5; k++) send_word(rtru_pkg::REQ_READ, '0, '0, '0, IDX_W'(k));
      send_word(REQ_NONE, rand_addr(), rand_end(), rand_prot(), rand_idx());
      // top byte, saturated end
      send_word(rtru_pkg::REQ_UNMAP, {AW{1'b1}}, {(AW + 1){1'b1}}, '0, '0);
      // past the count
      send_word(rtru_pkg::REQ_READ, '0, '0, '0, IDX_W'(DEPTH - 1));
      send_word(rtru_pkg::REQ_UNMAP, '0, ADDR_TOP, '0, '0);
   endtask

   // Fill the table, overflow it by append and by straddle, then clear it.
   task automatic test_full_table();
      logic [AW-1:0] b, a;
      b = rand_addr();
      b[19:0] = '0;
      a = b;
      for (int k = 0; k < DEPTH + 4; k++) begin
         send_word(rtru_pkg::REQ_TRACK, a, {1'b0, a} + 'h80, rand_prot(), rand_idx());
         a = a + 'h100;
      end
      // straddle, full
      send_word(rtru_pkg::REQ_UNMAP, b + 'h510, {1'b0, b} + 'h520, '0, '0);
      // frees one slot
      send_word(rtru_pkg::REQ_UNMAP, b + 'h1440, {1'b0, b} + 'h1640, '0, '0);
      // tail fits
      send_word(rtru_pkg::REQ_UNMAP, b + 'h2010, {1'b0, b} + 'h2020, '0, '0);
      // full again
      send_word(rtru_pkg::REQ_UNMAP, b + 'h3010, {1'b0, b} + 'h3020, '0, '0);
      for (int k = 0; k < 6; k++)
         send_word(rtru_pkg::REQ_READ, '0, '0, '0,
                   IDX_W'($urandom_range(0, tbl_count - 1)));
      send_word(rtru_pkg::REQ_UNMAP, '0, ADDR_TOP, '0, '0);
   endtask

   // Mostly well-formed traffic packed into a 4 KiB window so regions overlap;
   // the window moves every 100 words, sometimes to the bottom or top of the space.
   task automatic test_random();
      logic [AW-1:0]    win, lo;
      logic [AW:0]      hi;
      logic [IDX_W-1:0] idx;
      int               pick;
      win = '0;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 100 == 0) begin
            case ($urandom_range(0, 3))
               0: win = '0;
               1: win = {AW{1'b1}} - 'd4095;
               default: begin
                  win = rand_addr();
                  win[11:0] = '0;
               end
            endcase
         end
         lo   = win + $urandom_range(0, 4095);
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            hi = {1'b0, lo} + $urandom_range(1, 512);
            if ($urandom_range(0, 19) == 0) hi = {1'b0, lo} - $urandom_range(0, 2);
            send_word(rtru_pkg::REQ_TRACK, lo, hi, rand_prot(), rand_idx());
         end else if (pick < 68) begin
            hi = {1'b0, lo} + $urandom_range(0, 1024);
            if ($urandom_range(0, 24) == 0) begin
               // sweep the whole window
               lo = win;
               hi = {1'b0, win} + 'd8192;
            end else if ($urandom_range(0, 19) == 0) begin
               hi = {1'b0, lo} - $urandom_range(1, 64);
            end
            send_word(rtru_pkg::REQ_UNMAP, lo, hi, rand_prot(), rand_idx());
         end else if (pick < 92) begin
            // bias reads toward live entries
            if (tbl_count > 0 && $urandom_range(0, 3) != 0)
               idx = IDX_W'($urandom_range(0, tbl_count - 1));
            else
               idx = rand_idx();
            send_word(rtru_pkg::REQ_READ, rand_addr(), rand_end(), rand_prot(), idx);
         end else if (pick < 96) begin
            send_word(REQ_NONE, rand_addr(), rand_end(), rand_prot(), rand_idx());
         end else begin
            // noise over the full field ranges
            send_word(2'($urandom_range(0, 3)), rand_addr(), rand_end(), rand_prot(),
                      rand_idx());
         end
      end
   endtask

   // ---------------------------------------------------------------- checking
   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
         errors++;
      end
   endfunction

   // Every response word is taken at the edge that ends its cycle.
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid) begin
         if (due_rsp_q.size() == 0) begin
            $display("%0t: response word with none expected", $time);
            errors++;
         end else begin
            want = due_rsp_q.pop_front();
            check_field("entry_base", 64'(want.base), 64'(rsp_entry_base));
            check_field("entry_length", 64'(want.length), 64'(rsp_entry_length));
            check_field("entry_prot", 64'(want.prot), 64'(rsp_entry_prot));
            check_field("entry_present", 64'(want.present), 64'(rsp_entry_present));
            check_field("region_count", 64'(want.count), 64'(rsp_region_count));
            check_field("overflow", 64'(want.ovf), 64'(rsp_overflow));
         end
      end
   end

   // Watchdog: cycles with neither a request nor a response taken.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_table();
      test_random();
      start <= 1'b0;
      // drain, then a short tail to catch stray response words
      while (due_rsp_q.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule

### files.f
src/rtru_pkg.sv
src/rtru_ram.sv
src/rtru_region_eval.sv
src/region_table_range_unmap_unit.sv
sim/tb_top.sv
